### src/lpf_pkg.sv
// Package with the microcode types, step addresses and program for the largest prime factor block.
package lpf_pkg;

  localparam int STEP_W = 4;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE  = 4'd0;
  localparam step_t STEP_SMALL = 4'd1;
  localparam step_t STEP_EVEN  = 4'd2;
  localparam step_t STEP_HALVE = 4'd3;
  localparam step_t STEP_CINIT = 4'd4;
  localparam step_t STEP_TEST  = 4'd5;
  localparam step_t STEP_DIV   = 4'd6;
  localparam step_t STEP_CHECK = 4'd7;
  localparam step_t STEP_TAKE  = 4'd8;
  localparam step_t STEP_NEXT  = 4'd9;
  localparam step_t STEP_FINAL = 4'd10;
  localparam step_t STEP_EMIT  = 4'd11;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_IDLE,
    C_SMALL,
    C_ODD,
    C_SQ_GT,
    C_DIV_RUN,
    C_REM_NZ
  } cond_t;

  typedef enum logic [2:0] {
    A_NONE,
    A_LOAD,
    A_HALVE,
    A_CINIT,
    A_DSTART,
    A_DSTEP,
    A_TAKE,
    A_CNEXT
  } act_t;

  typedef enum logic [1:0] {
    O_NONE,
    O_FINAL,
    O_EMIT
  } out_op_t;

  typedef struct packed {
    cond_t   cond;
    step_t   target;
    act_t    act;
    out_op_t out_op;
  } ctrl_t;

  function automatic ctrl_t ucode(input step_t pc);
    ctrl_t w;
    w = '{cond: C_NEVER, target: STEP_IDLE, act: A_NONE, out_op: O_NONE};
    unique case (pc)
      STEP_IDLE:  w = '{cond: C_IDLE,    target: STEP_IDLE,  act: A_LOAD,   out_op: O_NONE};
      STEP_SMALL: w = '{cond: C_SMALL,   target: STEP_EMIT,  act: A_NONE,   out_op: O_NONE};
      STEP_EVEN:  w = '{cond: C_ODD,     target: STEP_CINIT, act: A_NONE,   out_op: O_NONE};
      STEP_HALVE: w = '{cond: C_ALWAYS,  target: STEP_EVEN,  act: A_HALVE,  out_op: O_NONE};
      STEP_CINIT: w = '{cond: C_NEVER,   target: STEP_IDLE,  act: A_CINIT,  out_op: O_NONE};
      STEP_TEST:  w = '{cond: C_SQ_GT,   target: STEP_FINAL, act: A_DSTART, out_op: O_NONE};
      STEP_DIV:   w = '{cond: C_DIV_RUN, target: STEP_DIV,   act: A_DSTEP,  out_op: O_NONE};
      STEP_CHECK: w = '{cond: C_REM_NZ,  target: STEP_NEXT,  act: A_NONE,   out_op: O_NONE};
      STEP_TAKE:  w = '{cond: C_ALWAYS,  target: STEP_TEST,  act: A_TAKE,   out_op: O_NONE};
      STEP_NEXT:  w = '{cond: C_ALWAYS,  target: STEP_TEST,  act: A_CNEXT,  out_op: O_NONE};
      STEP_FINAL: w = '{cond: C_NEVER,   target: STEP_IDLE,  act: A_NONE,   out_op: O_FINAL};
      STEP_EMIT:  w = '{cond: C_ALWAYS,  target: STEP_IDLE,  act: A_NONE,   out_op: O_EMIT};
      default:    w = '{cond: C_ALWAYS,  target: STEP_IDLE,  act: A_NONE,   out_op: O_NONE};
    endcase
    return w;
  endfunction

endpackage

### src/largest_prime_factor.sv
// Largest prime factor by trial division, driven by a microcoded sequencer.
// Values below two skip the search. The bit-serial divider yields one quotient bit per cycle.
// One item at a time: busy drops while the result is shown, so the next beat can be taken
// at that edge. Reset is synchronous, returns to idle.
module largest_prime_factor #(
  parameter int VALUE_WIDTH = 31
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  output logic [VALUE_WIDTH-1:0] out_factor,
  output logic                   out_valid_res
);

  localparam int CW    = VALUE_WIDTH / 2 + 2;
  localparam int SW    = VALUE_WIDTH + 1;
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  lpf_pkg::step_t         pc_r, pc_nxt;
  lpf_pkg::ctrl_t         ctrl;
  logic                   cond_hit;
  logic [VALUE_WIDTH-1:0] rest_r, rest_nxt;
  logic [VALUE_WIDTH-1:0] best_r, best_nxt;
  logic                   vres_r, vres_nxt;
  logic [CW-1:0]          cand_r, cand_nxt;
  logic [SW-1:0]          sq_r, sq_nxt;
  logic [VALUE_WIDTH-1:0] quot_r, quot_nxt;
  logic [CW-1:0]          rem_r, rem_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CW:0]            trial;
  logic                   out_valid_r, out_valid_nxt;
  logic [VALUE_WIDTH-1:0] out_factor_r, out_factor_nxt;
  logic                   out_vres_r, out_vres_nxt;

  assign ctrl  = lpf_pkg::ucode(pc_r);
  assign trial = {rem_r, quot_r[VALUE_WIDTH-1]};

  always_comb begin
    unique case (ctrl.cond)
      lpf_pkg::C_NEVER:   cond_hit = 1'b0;
      lpf_pkg::C_ALWAYS:  cond_hit = 1'b1;
      lpf_pkg::C_IDLE:    cond_hit = !start;
      lpf_pkg::C_SMALL:   cond_hit = (rest_r[VALUE_WIDTH-1:1] == '0);
      lpf_pkg::C_ODD:     cond_hit = rest_r[0];
      lpf_pkg::C_SQ_GT:   cond_hit = (sq_r > {1'b0, rest_r});
      lpf_pkg::C_DIV_RUN: cond_hit = (cnt_r != CNT_W'(1));
      lpf_pkg::C_REM_NZ:  cond_hit = (rem_r != '0);
      default:            cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt         = cond_hit ? ctrl.target : pc_r + lpf_pkg::step_t'(1);
    rest_nxt       = rest_r;
    best_nxt       = best_r;
    vres_nxt       = vres_r;
    cand_nxt       = cand_r;
    sq_nxt         = sq_r;
    quot_nxt       = quot_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = 1'b0;
    out_factor_nxt = out_factor_r;
    out_vres_nxt   = out_vres_r;

    unique case (ctrl.act)
      lpf_pkg::A_NONE: begin
      end
      lpf_pkg::A_LOAD: begin
        if (start) begin
          rest_nxt = in_value;
          best_nxt = '0;
          vres_nxt = (in_value[VALUE_WIDTH-1:1] != '0);
        end
      end
      lpf_pkg::A_HALVE: begin
        rest_nxt = rest_r >> 1;
        best_nxt = VALUE_WIDTH'(2);
      end
      lpf_pkg::A_CINIT: begin
        cand_nxt = CW'(3);
        sq_nxt   = SW'(9);
      end
      lpf_pkg::A_DSTART: begin
        quot_nxt = rest_r;
        rem_nxt  = '0;
        cnt_nxt  = CNT_W'(VALUE_WIDTH);
      end
      lpf_pkg::A_DSTEP: begin
        if (trial >= {1'b0, cand_r}) begin
          rem_nxt  = CW'(trial - {1'b0, cand_r});
          quot_nxt = {quot_r[VALUE_WIDTH-2:0], 1'b1};
        end else begin
          rem_nxt  = trial[CW-1:0];
          quot_nxt = {quot_r[VALUE_WIDTH-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      lpf_pkg::A_TAKE: begin
        rest_nxt = quot_r;
        best_nxt = VALUE_WIDTH'(cand_r);
      end
      lpf_pkg::A_CNEXT: begin
        cand_nxt = cand_r + CW'(2);
        sq_nxt   = sq_r + SW'({cand_r, 2'b00}) + SW'(4);
      end
      default: begin
      end
    endcase

    unique case (ctrl.out_op)
      lpf_pkg::O_NONE: begin
      end
      lpf_pkg::O_FINAL: begin
        if (rest_r > VALUE_WIDTH'(2)) begin
          best_nxt = rest_r;
        end
      end
      lpf_pkg::O_EMIT: begin
        out_valid_nxt  = 1'b1;
        out_factor_nxt = best_r;
        out_vres_nxt   = vres_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= lpf_pkg::STEP_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rest_r       <= rest_nxt;
    best_r       <= best_nxt;
    vres_r       <= vres_nxt;
    cand_r       <= cand_nxt;
    sq_r         <= sq_nxt;
    quot_r       <= quot_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    out_factor_r <= out_factor_nxt;
    out_vres_r   <= out_vres_nxt;
  end

  assign busy          = (pc_r != lpf_pkg::STEP_IDLE);
  assign out_valid     = out_valid_r;
  assign out_factor    = out_factor_r;
  assign out_valid_res = out_vres_r;

endmodule

### dv/tb.sv
// Self-checking testbench for the largest prime factor block: command-style stimulus and checks.
module tb;

  localparam int VW = 31;
  localparam int unsigned RANDOM_ITEMS = 100;
  localparam int unsigned TRY_CAP = 300;

  typedef struct packed {
    logic [VW-1:0] factor;
    logic          valid_res;
  } factor_res_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic [VW-1:0] in_value = '0;
  logic          busy;
  logic          out_valid;
  logic [VW-1:0] out_factor;
  logic          out_valid_res;

  logic [VW-1:0] value_q[$];
  factor_res_t   factor_q[$];
  int unsigned   gap_left = 0;
  int unsigned   mismatches = 0;

  largest_prime_factor #(.VALUE_WIDTH(VW)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_factor(out_factor),
    .out_valid_res(out_valid_res)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Trial division; stops early once more than try_cap odd candidates have been tried.
  function automatic factor_res_t largest_factor_of(input logic [VW-1:0] value,
                                                    input int unsigned try_cap,
                                                    output int unsigned tries);
    factor_res_t r;
    logic [63:0] rest;
    logic [63:0] cand;
    logic [63:0] best;
    tries = 0;
    r.factor = '0;
    r.valid_res = 1'b0;
    if (value >= 2) begin
      rest = 64'(value);
      best = 64'd0;
      while (rest[0] == 1'b0) begin
        best = 64'd2;
        rest = rest >> 1;
      end
      cand = 64'd3;
      while (cand * cand <= rest && tries <= try_cap) begin
        tries++;
        while (rest % cand == 64'd0) begin
          best = cand;
          rest = rest / cand;
        end
        cand = cand + 64'd2;
      end
      if (rest > 64'd2) begin
        best = rest;
      end
      r.factor = best[VW-1:0];
      r.valid_res = 1'b1;
    end
    return r;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      start <= 1'b0;
      in_value <= VW'($urandom);
      if (!busy) begin
        gap_left <= gap_left - 1;
      end
    end else if (value_q.size() > 0) begin
      start <= 1'b1;
      in_value <= value_q[0];
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    factor_res_t exp_res;
    int unsigned tries;
    if (rst_n) begin
      if (start && !busy) begin
        factor_q.push_back(largest_factor_of(in_value, 32'hFFFF_FFFF, tries));
        void'(value_q.pop_front());
        if (value_q.size() > 12 && $urandom_range(0, 2) == 0) begin
          gap_left <= $urandom_range(1, 9);
        end
      end
      if (out_valid) begin
        if (factor_q.size() == 0) begin
          $display("%0t: unexpected result beat factor %0d valid_res %0b",
                   $time, out_factor, out_valid_res);
          mismatches++;
        end else begin
          exp_res = factor_q.pop_front();
          if (out_factor !== exp_res.factor) begin
            $display("%0t: factor expected %0d actual %0d", $time, exp_res.factor, out_factor);
            mismatches++;
          end
          if (out_valid_res !== exp_res.valid_res) begin
            $display("%0t: valid_res expected %0b actual %0b",
                     $time, exp_res.valid_res, out_valid_res);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    logic [VW-1:0] v;
    logic [63:0]   m;
    logic [63:0]   limit;
    logic [63:0]   f;
    int unsigned   s;
    int unsigned   kind;
    int unsigned   tries;
    bit            growing;
    factor_res_t   unused;

    value_q = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd8, 31'd9, 31'd12, 31'd25,
                31'd49, 31'd97, 31'd30030, 31'd65521, 31'd65537, 31'd1000000, 31'd1042441,
                31'd715827882, 31'd1073741824, 31'd1162261467, 31'd1431655765,
                31'd2147483646, 31'd2147483647};

    // Random values are kept only when the number of trial candidates stays small.
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      do begin
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
          v = VW'($urandom);
        end else if (kind <= 6) begin
          m = 64'd1;
          limit = 64'd1 << $urandom_range(2, VW);
          growing = 1'b1;
          while (growing) begin
            f = 64'($urandom_range(3, 61));
            if (m * f >= limit) begin
              growing = 1'b0;
            end else begin
              m = m * f;
            end
          end
          s = $urandom_range(0, VW - 1);
          while ((m << s) >= (64'd1 << VW)) begin
            s--;
          end
          v = VW'(m << s);
        end else if (kind <= 8) begin
          v = VW'($urandom_range(0, 4095));
        end else begin
          v = VW'($urandom_range(0, 65535)) << $urandom_range(0, 15);
        end
        unused = largest_factor_of(v, TRY_CAP, tries);
      end while (tries > TRY_CAP);
      value_q.push_back(v);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (value_q.size() != 0 || factor_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
